// File: hw/rtl/contact_point_cache_defines.svh
// Assertion macros used by the checker of the contact point cache.
`ifndef CONTACT_POINT_CACHE_DEFINES_SVH
`define CONTACT_POINT_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cpc_pkg.sv
package cpc_pkg;

  localparam int DefSlots = 4;

  localparam int CoordW   = 24;
  localparam int RadW     = 52;
  localparam int SqW      = 48;
  localparam int SumW     = 50;
  localparam int SlotW    = 4;
  localparam int ActW     = 3;
  localparam int CntW     = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 52;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_PAIR_READY   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MATCH_RADIUS = 1'd1;

  localparam logic [ActW-1:0] ACT_UPDATED  = 3'd0;
  localparam logic [ActW-1:0] ACT_KEPT     = 3'd1;
  localparam logic [ActW-1:0] ACT_INSERTED = 3'd2;
  localparam logic [ActW-1:0] ACT_REPLACED = 3'd3;
  localparam logic [ActW-1:0] ACT_DROPPED  = 3'd4;
  localparam logic [ActW-1:0] ACT_CLEARED  = 3'd5;

  typedef struct packed {
    logic load;
    logic clear;
    logic drop;
    logic scan;
    logic commit;
  } cpc_cmd_t;

  typedef struct packed {
    logic last;
  } cpc_sts_t;

endpackage

// File: hw/rtl/cpc_ctrl.sv
module cpc_ctrl
  import cpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     op_i,
  input  logic     pair_ready_i,
  input  cpc_sts_t sts_i,
  output cpc_cmd_t cmd_o,
  output logic     busy_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (op_i == OP_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else if (!pair_ready_i) begin
            cmd_o.drop = 1'b1;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) begin
          state_d = StDrain;
        end
      end
      // The last slot's squares are still in the pipeline register here.
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// File: hw/rtl/cpc_dp.sv
module cpc_dp
  import cpc_pkg::*;
#(
  parameter int Slots = DefSlots
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cpc_cmd_t                 cmd_i,
  output cpc_sts_t                 sts_o,
  input  logic        [RadW-1:0]   radius_i,
  input  logic signed [CoordW-1:0] local_b_x_i,
  input  logic signed [CoordW-1:0] local_b_y_i,
  input  logic signed [CoordW-1:0] local_b_z_i,
  input  logic signed [CoordW-1:0] depth_i,
  output logic                     done_o,
  output logic        [SlotW-1:0]  slot_o,
  output logic        [ActW-1:0]   action_o,
  output logic        [CntW-1:0]   valid_count_o
);

  localparam int IdxW = (Slots > 1) ? $clog2(Slots) : 1;

  function automatic logic [CntW-1:0] count_ones(input logic [Slots-1:0] v);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = 0; i < Slots; i++) begin
      n = n + CntW'(v[i]);
    end
    return n;
  endfunction

  // Slot storage; an entry only counts toward a match once its valid bit is set.
  logic signed [CoordW-1:0] pos_x_q [Slots];
  logic signed [CoordW-1:0] pos_y_q [Slots];
  logic signed [CoordW-1:0] pos_z_q [Slots];
  logic signed [CoordW-1:0] dist_q  [Slots];
  logic        [Slots-1:0]  valid_q, valid_nxt;

  logic signed [CoordW-1:0] x_q, y_q, z_q, d_q;
  logic        [IdxW-1:0]   idx_q;

  // Stage 1: one slot read, three squared differences.
  logic signed [CoordW:0]     dx, dy, dz;
  logic signed [2*CoordW+1:0] px, py, pz;
  logic                       s1_go_q;
  logic        [SqW-1:0]      sqx_q, sqy_q, sqz_q;
  logic        [IdxW-1:0]     s1_idx_q;
  logic                       s1_valid_q;
  logic signed [CoordW-1:0]   s1_dist_q;

  // Stage 2: nearest and farthest tracking.
  logic        [SumW-1:0]   sum;
  logic        [RadW-1:0]   best_q;
  logic                     found_q;
  logic        [IdxW-1:0]   near_q, far_q;
  logic signed [CoordW-1:0] near_dist_q, far_dist_q;

  logic                     has_empty;
  logic        [IdxW-1:0]   empty_idx;
  logic                     wen;
  logic        [IdxW-1:0]   widx;
  logic        [ActW-1:0]   act;

  logic                     done_q;
  logic        [SlotW-1:0]  slot_q;
  logic        [ActW-1:0]   action_q;
  logic        [CntW-1:0]   count_q;

  assign sts_o.last = (idx_q == IdxW'(Slots - 1));

  always_comb begin
    dx = {pos_x_q[idx_q][CoordW-1], pos_x_q[idx_q]} - {x_q[CoordW-1], x_q};
    dy = {pos_y_q[idx_q][CoordW-1], pos_y_q[idx_q]} - {y_q[CoordW-1], y_q};
    dz = {pos_z_q[idx_q][CoordW-1], pos_z_q[idx_q]} - {z_q[CoordW-1], z_q};
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
  end

  assign sum = SumW'(sqx_q) + SumW'(sqy_q) + SumW'(sqz_q);

  always_comb begin
    has_empty = ~&valid_q;
    empty_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        empty_idx = IdxW'(i);
      end
    end
  end

  // Placement decision at the end of the scan.
  always_comb begin
    wen = 1'b0;
    widx = near_q;
    act = ACT_KEPT;
    if (found_q) begin
      if (d_q < near_dist_q) begin
        wen = 1'b1;
        act = ACT_UPDATED;
      end
    end else if (has_empty) begin
      wen  = 1'b1;
      widx = empty_idx;
      act  = ACT_INSERTED;
    end else begin
      wen  = 1'b1;
      widx = far_q;
      act  = ACT_REPLACED;
    end
    valid_nxt = valid_q;
    if (wen) begin
      valid_nxt[widx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
      s1_go_q <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      s1_go_q <= cmd_i.scan;
      done_q  <= cmd_i.clear | cmd_i.drop | cmd_i.commit;
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (s1_go_q && s1_valid_q && (RadW'(sum) < best_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.commit) begin
        valid_q <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= local_b_x_i;
      y_q    <= local_b_y_i;
      z_q    <= local_b_z_i;
      d_q    <= depth_i;
      best_q <= radius_i;
    end
    if (cmd_i.scan) begin
      sqx_q      <= px[SqW-1:0];
      sqy_q      <= py[SqW-1:0];
      sqz_q      <= pz[SqW-1:0];
      s1_idx_q   <= idx_q;
      s1_valid_q <= valid_q[idx_q];
      s1_dist_q  <= dist_q[idx_q];
    end
    if (s1_go_q) begin
      if (s1_valid_q && (RadW'(sum) < best_q)) begin
        best_q      <= RadW'(sum);
        near_q      <= s1_idx_q;
        near_dist_q <= s1_dist_q;
      end
      // Farthest is only used when every slot is valid.
      if ((s1_idx_q == '0) || (s1_dist_q > far_dist_q)) begin
        far_q      <= s1_idx_q;
        far_dist_q <= s1_dist_q;
      end
    end
    if (cmd_i.commit && wen) begin
      pos_x_q[widx] <= x_q;
      pos_y_q[widx] <= y_q;
      pos_z_q[widx] <= z_q;
      dist_q[widx]  <= d_q;
    end
    if (cmd_i.clear) begin
      slot_q   <= '0;
      action_q <= ACT_CLEARED;
      count_q  <= '0;
    end else if (cmd_i.drop) begin
      slot_q   <= '0;
      action_q <= ACT_DROPPED;
      count_q  <= count_ones(valid_q);
    end else if (cmd_i.commit) begin
      slot_q   <= SlotW'(widx);
      action_q <= act;
      count_q  <= count_ones(valid_nxt);
    end
  end

  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign action_o      = action_q;
  assign valid_count_o = count_q;

endmodule

// File: hw/rtl/contact_point_cache.sv
// Contact point cache for one body pair. An item is accepted when start_i is
// high while busy_o is low, and gives exactly one result beat, shown for one
// cycle with done_o high; the receiver cannot stall it. A clear, or an add
// while the pair is not ready, returns its beat in the cycle after it is
// accepted and the block is ready again at once. An add scans the slots one a
// cycle through a two-stage squared-distance pipeline, then commits: it holds
// busy_o through the scan, a drain state and the commit state, and its beat
// comes in the first cycle with busy_o low again. Configuration writes take
// effect at once and belong only to idle periods.
module contact_point_cache
  import cpc_pkg::*;
#(
  parameter int Slots = DefSlots
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic        [CfgIdxW-1:0] cfg_idx_i,
  input  logic        [CfgDataW-1:0] cfg_wdata_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     op_i,
  input  logic signed [CoordW-1:0] local_b_x_i,
  input  logic signed [CoordW-1:0] local_b_y_i,
  input  logic signed [CoordW-1:0] local_b_z_i,
  input  logic signed [CoordW-1:0] depth_i,
  output logic                     done_o,
  output logic        [SlotW-1:0]  slot_o,
  output logic        [ActW-1:0]   action_o,
  output logic        [CntW-1:0]   valid_count_o
);

  logic            pair_ready_q;
  logic [RadW-1:0] radius_q;
  cpc_cmd_t        cmd;
  cpc_sts_t        sts;
  logic            busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_ready_q <= 1'b0;
      radius_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAIR_READY:   pair_ready_q <= cfg_wdata_i[0];
        REG_MATCH_RADIUS: radius_q     <= cfg_wdata_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  cpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .pair_ready_i (pair_ready_q),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy)
  );

  cpc_dp #(
    .Slots (Slots)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .radius_i      (radius_q),
    .local_b_x_i   (local_b_x_i),
    .local_b_y_i   (local_b_y_i),
    .local_b_z_i   (local_b_z_i),
    .depth_i       (depth_i),
    .done_o        (done_o),
    .slot_o        (slot_o),
    .action_o      (action_o),
    .valid_count_o (valid_count_o)
  );

  assign busy_o = busy;

endmodule

// File: hw/rtl/cpc_chk.sv
`include "contact_point_cache_defines.svh"

module cpc_chk
  import cpc_pkg::*;
#(
  parameter int Slots = DefSlots
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic [CfgDataW-1:0] cfg_wdata_i,
  input logic                start_i,
  input logic                busy_o,
  input logic                op_i,
  input logic [CoordW-1:0]   local_b_x_i,
  input logic [CoordW-1:0]   local_b_y_i,
  input logic [CoordW-1:0]   local_b_z_i,
  input logic [CoordW-1:0]   depth_i,
  input logic                done_o,
  input logic [SlotW-1:0]    slot_o,
  input logic [ActW-1:0]     action_o,
  input logic [CntW-1:0]     valid_count_o
);

  // A clear beat always reports an empty cache at slot zero.
  `CPC_ASSERT_IMP(a_clear_empty, done_o && (action_o == ACT_CLEARED), (valid_count_o == '0) && (slot_o == '0), "clear beat with nonzero slot or count")

  // A clear is answered in the very next cycle.
  `CPC_ASSERT_NXT(a_clear_next, start_i && !busy_o && (op_i == OP_CLEAR), done_o && (action_o == ACT_CLEARED) && !busy_o, "clear not answered next cycle")

  // A result beat only comes once the item is fully finished.
  `CPC_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result beat while busy")

  // Reported slots and counts stay within the configured slot count.
  `CPC_ASSERT_IMP(a_slot_range, done_o, (32'(slot_o) < Slots) && (32'(valid_count_o) <= Slots), "slot or count out of range")

endmodule

bind contact_point_cache cpc_chk #(.Slots(Slots)) u_cpc_chk (.*);

// File: verif/cpc_checker.sv
// Watches the command, configuration and result channels of the contact point
// cache, keeps its own copy of the slots, predicts each result beat and
// compares it with what the block returns.
module cpc_checker
  import cpc_pkg::*;
#(
  parameter int Slots = DefSlots
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic                      op_i,
  input  logic signed [CoordW-1:0]  local_b_x_i,
  input  logic signed [CoordW-1:0]  local_b_y_i,
  input  logic signed [CoordW-1:0]  local_b_z_i,
  input  logic signed [CoordW-1:0]  depth_i,
  input  logic                      done_i,
  input  logic [SlotW-1:0]          slot_i,
  input  logic [ActW-1:0]           action_i,
  input  logic [CntW-1:0]           valid_count_i,
  output int                        pending_o,
  output int                        fail_count_o,
  output logic [5:0][31:0]          action_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [ActW-1:0]  action;
    logic [CntW-1:0]  count;
  } cache_outcome_t;

  cache_outcome_t           outcome_q[$];
  cache_outcome_t           due;
  logic                     slot_live  [Slots];
  logic signed [CoordW-1:0] slot_x     [Slots];
  logic signed [CoordW-1:0] slot_y     [Slots];
  logic signed [CoordW-1:0] slot_z     [Slots];
  logic signed [CoordW-1:0] slot_depth [Slots];
  logic                     ready_q;
  logic [RadW-1:0]          radius_sq_q;
  logic                     beat_ok;

  function automatic longint unsigned axis_sq(input logic signed [CoordW-1:0] a,
                                              input logic signed [CoordW-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return diff * diff;
  endfunction

  function automatic void store_point(input int idx,
                                      input logic signed [CoordW-1:0] x,
                                      input logic signed [CoordW-1:0] y,
                                      input logic signed [CoordW-1:0] z,
                                      input logic signed [CoordW-1:0] d);
    slot_live[idx]  = 1'b1;
    slot_x[idx]     = x;
    slot_y[idx]     = y;
    slot_z[idx]     = z;
    slot_depth[idx] = d;
  endfunction

  function automatic cache_outcome_t apply_item(input logic op,
                                                input logic signed [CoordW-1:0] x,
                                                input logic signed [CoordW-1:0] y,
                                                input logic signed [CoordW-1:0] z,
                                                input logic signed [CoordW-1:0] d);
    cache_outcome_t  res;
    longint unsigned best;
    longint unsigned span_sq;
    int              nearest;
    int              target;
    int              live;
    res = '0;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < Slots; i++) slot_live[i] = 1'b0;
      res.action = ACT_CLEARED;
    end else if (!ready_q) begin
      res.action = ACT_DROPPED;
    end else begin
      // The threshold seeds the running minimum, so only strictly closer slots win
      // and the lowest index keeps a tie.
      best    = radius_sq_q;
      nearest = -1;
      for (int i = 0; i < Slots; i++) begin
        if (slot_live[i]) begin
          span_sq = axis_sq(slot_x[i], x) + axis_sq(slot_y[i], y) + axis_sq(slot_z[i], z);
          if (span_sq < best) begin
            best    = span_sq;
            nearest = i;
          end
        end
      end
      if (nearest >= 0) begin
        res.slot = SlotW'(nearest);
        if (d < slot_depth[nearest]) begin
          store_point(nearest, x, y, z, d);
          res.action = ACT_UPDATED;
        end else begin
          res.action = ACT_KEPT;
        end
      end else begin
        target = -1;
        for (int i = Slots - 1; i >= 0; i--) begin
          if (!slot_live[i]) target = i;
        end
        if (target >= 0) begin
          res.action = ACT_INSERTED;
        end else begin
          target = 0;
          for (int i = 1; i < Slots; i++) begin
            if (slot_depth[i] > slot_depth[target]) target = i;
          end
          res.action = ACT_REPLACED;
        end
        store_point(target, x, y, z, d);
        res.slot = SlotW'(target);
      end
    end
    live = 0;
    for (int i = 0; i < Slots; i++) begin
      if (slot_live[i]) live++;
    end
    res.count = CntW'(live);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outcome_q.delete();
      for (int i = 0; i < Slots; i++) begin
        slot_live[i]  = 1'b0;
        slot_x[i]     = '0;
        slot_y[i]     = '0;
        slot_z[i]     = '0;
        slot_depth[i] = '0;
      end
      ready_q       = 1'b0;
      radius_sq_q   = '0;
      fail_count_o  = 0;
      pending_o     = 0;
      action_hits_o = '0;
    end else begin
      // Results are compared before this edge's command is predicted: a beat
      // accepted now can never belong to an item accepted at the same edge.
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: slot %0d action %0d count %0d",
                   $time, slot_i, action_i, valid_count_i);
          fail_count_o++;
        end else begin
          due     = outcome_q.pop_front();
          beat_ok = 1'b1;
          if (slot_i !== due.slot) begin
            $display("%0t: slot mismatch, expected %0d, actual %0d", $time, due.slot, slot_i);
            beat_ok = 1'b0;
          end
          if (action_i !== due.action) begin
            $display("%0t: action mismatch, expected %0d, actual %0d",
                     $time, due.action, action_i);
            beat_ok = 1'b0;
          end
          if (valid_count_i !== due.count) begin
            $display("%0t: valid_count mismatch, expected %0d, actual %0d",
                     $time, due.count, valid_count_i);
            beat_ok = 1'b0;
          end
          if (beat_ok) begin
            action_hits_o[due.action] = action_hits_o[due.action] + 1;
          end else begin
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAIR_READY:   ready_q     = cfg_wdata_i[0];
          REG_MATCH_RADIUS: radius_sq_q = cfg_wdata_i[RadW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        outcome_q.push_back(apply_item(op_i, local_b_x_i, local_b_y_i, local_b_z_i, depth_i));
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpc_pkg::*;

  localparam int          Slots      = DefSlots;
  localparam int          ItemTarget = 1750;
  localparam int unsigned CycleLimit = 400_000;
  localparam int          PoolDepth  = 8;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i   = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     start_i     = 1'b0;
  logic                     op_i        = OP_ADD;
  logic signed [CoordW-1:0] local_b_x_i = '0;
  logic signed [CoordW-1:0] local_b_y_i = '0;
  logic signed [CoordW-1:0] local_b_z_i = '0;
  logic signed [CoordW-1:0] depth_i     = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [SlotW-1:0]         slot_o;
  logic [ActW-1:0]          action_o;
  logic [CntW-1:0]          valid_count_o;

  int                       pending;
  int                       fail_count;
  logic [5:0][31:0]         action_hits;
  int unsigned              cycle_count    = 0;
  int                       gap_max        = 10;
  int                       items_sent     = 0;
  int                       settings_used  = 0;
  int                       pool_wr        = 0;

  // Recently sent points, reused with small offsets so that adds land inside
  // the match radius of cached slots.
  logic signed [CoordW-1:0] pool_x [PoolDepth] = '{default: '0};
  logic signed [CoordW-1:0] pool_y [PoolDepth] = '{default: '0};
  logic signed [CoordW-1:0] pool_z [PoolDepth] = '{default: '0};
  logic signed [CoordW-1:0] pool_d [PoolDepth] = '{default: '0};

  always #4 clk_i = ~clk_i;

  contact_point_cache #(.Slots(Slots)) dut (.*);

  cpc_checker #(.Slots(Slots)) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .start_i,
    .busy_i        (busy_o),
    .op_i,
    .local_b_x_i,
    .local_b_y_i,
    .local_b_z_i,
    .depth_i,
    .done_i        (done_o),
    .slot_i        (slot_o),
    .action_i      (action_o),
    .valid_count_i (valid_count_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .action_hits_o (action_hits)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("contact_point_cache regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic configure(input logic ready, input logic [RadW-1:0] radius);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(REG_PAIR_READY, {noise[CfgDataW-2:0], ready});
    write_reg(REG_MATCH_RADIUS, CfgDataW'(radius));
    settings_used++;
  endtask

  // Holds the sender off until every outstanding beat has come back.
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Slots + 6) @(negedge clk_i);
  endtask

  task automatic send(input logic op,
                      input logic signed [CoordW-1:0] x,
                      input logic signed [CoordW-1:0] y,
                      input logic signed [CoordW-1:0] z,
                      input logic signed [CoordW-1:0] d);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      start_i     <= 1'b0;
      op_i        <= 1'($urandom);
      local_b_x_i <= CoordW'($urandom);
      local_b_y_i <= CoordW'($urandom);
      local_b_z_i <= CoordW'($urandom);
      depth_i     <= CoordW'($urandom);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    op_i        <= op;
    local_b_x_i <= x;
    local_b_y_i <= y;
    local_b_z_i <= z;
    depth_i     <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_ADD) begin
      pool_x[pool_wr] = x;
      pool_y[pool_wr] = y;
      pool_z[pool_wr] = z;
      pool_d[pool_wr] = d;
      pool_wr = (pool_wr + 1) % PoolDepth;
    end
  endtask

  function automatic logic signed [CoordW-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return '0;
      3:       return '1;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Full-range value scaled down by a random shift, so magnitudes of all sizes occur.
  function automatic logic signed [CoordW-1:0] fresh_coord();
    logic signed [CoordW-1:0] v;
    v = CoordW'($urandom);
    return v >>> $urandom_range(0, 16);
  endfunction

  function automatic logic signed [CoordW-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CoordW'(int'($urandom_range(0, 10)) - 5);
    else if (r < 50) return corner_value();
    else return CoordW'($urandom);
  endfunction

  task automatic random_item();
    int                       r;
    int                       k;
    int                       spread;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] d;
    r = $urandom_range(0, 99);
    x = fresh_coord();
    y = fresh_coord();
    z = fresh_coord();
    d = pick_depth();
    if (r >= 4 && r < 50) begin
      k = $urandom_range(0, PoolDepth - 1);
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = 16;
        2:       spread = 255;
        3:       spread = 4095;
        default: spread = 65535;
      endcase
      x = pool_x[k] + CoordW'(int'($urandom_range(0, 2 * spread)) - spread);
      y = pool_y[k] + CoordW'(int'($urandom_range(0, 2 * spread)) - spread);
      z = pool_z[k] + CoordW'(int'($urandom_range(0, 2 * spread)) - spread);
      case ($urandom_range(0, 3))
        0:       d = pool_d[k];
        1:       d = pool_d[k] - 1;
        2:       d = pool_d[k] + 1;
        default: ;
      endcase
    end else if (r >= 85) begin
      x = corner_value();
      y = corner_value();
      z = corner_value();
    end
    send((r < 4) ? OP_CLEAR : OP_ADD, x, y, z, d);
  endtask

  initial begin : stimulus
    logic            ready;
    logic [RadW-1:0] radius;
    int              phase;
    int              counted;
    int              burst;
    phase   = 0;
    counted = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pair not ready: the add is dropped, the clear still acts.
    send(OP_ADD, 1, 2, 3, 4);
    send(OP_CLEAR, CoordMax, CoordMin, 0, 0);
    settle();
    configure(1'b1, '0);

    // Zero threshold: identical points never match, so the cache fills and the
    // deepest slot is replaced.
    send(OP_ADD, CoordMax, CoordMax, CoordMax, CoordMax);
    send(OP_ADD, CoordMin, CoordMin, CoordMin, CoordMin);
    send(OP_ADD, 0, 0, 0, 0);
    send(OP_ADD, 0, 0, 0, 0);
    send(OP_ADD, 5, 5, 5, 0);
    send(OP_CLEAR, 0, 0, 0, 0);
    // Equal depths everywhere: the lowest slot is the one replaced.
    for (int i = 1; i <= 5; i++) send(OP_ADD, 100 * i, 0, 0, 7);
    settle();
    configure(1'b1, 52'd1000);

    // Two slots equally near the new point, then equal, smaller and larger depths.
    send(OP_CLEAR, 0, 0, 0, 0);
    send(OP_ADD, 20, 0, 0, 0);
    send(OP_ADD, -20, 0, 0, 0);
    send(OP_ADD, 0, 0, 0, 3);
    send(OP_ADD, 20, 0, 0, 0);
    send(OP_ADD, 20, 0, 0, -1);
    send(OP_ADD, 21, 0, 0, 5);
    settle();
    configure(1'b1, '1);

    // Largest threshold: opposite corners of the coordinate range still match.
    send(OP_ADD, CoordMin, CoordMin, CoordMin, CoordMax);
    send(OP_ADD, CoordMax, CoordMax, CoordMax, CoordMin);

    while (counted < ItemTarget) begin
      settle();
      ready = (phase % 5 != 3);
      case (phase % 6)
        0:       radius = '0;
        1:       radius = '1;
        2:       radius = RadW'(64'h1_0000_0000);
        3:       radius = RadW'({$urandom, $urandom});
        4:       radius = RadW'($urandom_range(1, 1 << 20));
        default: radius = RadW'(64'h100_0000_0000);
      endcase
      configure(ready, radius);
      // Every third phase runs back to back with no gaps at all.
      gap_max = (phase % 3 == 0) ? 0 : 10;
      burst   = ready ? $urandom_range(120, 220) : 30;
      repeat (burst) random_item();
      if (ready) counted += burst;
      phase++;
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items under %0d register settings in %0d cycles.",
             items_sent, settings_used, cycle_count);
    $display("Beats: %0d updated, %0d kept, %0d inserted, %0d replaced, %0d dropped, %0d cleared.",
             action_hits[ACT_UPDATED], action_hits[ACT_KEPT], action_hits[ACT_INSERTED],
             action_hits[ACT_REPLACED], action_hits[ACT_DROPPED], action_hits[ACT_CLEARED]);
    if (fail_count == 0 && pending == 0) begin
      $display("contact_point_cache regression: pass");
    end else begin
      $display("contact_point_cache regression: fail");
    end
    $finish;
  end

endmodule
